// ===== design/jdc_pkg.sv =====
// shared types, constants and huffman table for the dc entropy coder
package jdc_pkg;

	localparam int COEFF_BITS_DEF = 12;

	// action codes of the input item, also used as command kinds in the queue
	localparam logic [1:0] ACT_CODE    = 2'd0;
	localparam logic [1:0] ACT_FLUSH   = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	// component codes
	localparam logic [1:0] COMP_LUMA = 2'd0;
	localparam logic [1:0] COMP_CB   = 2'd1;
	localparam logic [1:0] COMP_CR   = 2'd2;

	// widths of the coded bit packet
	localparam int CAT_W  = 4;
	localparam int MAG_W  = 11;
	localparam int HUFF_W = 11;
	localparam int PKT_W  = 24;
	localparam int LEN_W  = 5;
	localparam int SAT_W  = 12;
	localparam int DIFF_LIMIT = 2047;

	// end-of-block codes
	localparam logic [3:0]       EOB_LUMA       = 4'hA;
	localparam logic [LEN_W-1:0] EOB_LUMA_LEN   = 5'd4;
	localparam logic [LEN_W-1:0] EOB_CHROMA_LEN = 5'd2;

	localparam logic [7:0] BYTE_FF    = 8'hFF;
	localparam logic [7:0] BYTE_STUFF = 8'h00;

	typedef struct packed {
		logic [1:0]       kind;
		logic [PKT_W-1:0] bits;
		logic [LEN_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic [HUFF_W-1:0] code;
		logic [3:0]        len;
	} huff_t;

	// baseline dc huffman code for a size category
	function automatic huff_t dc_huff(input logic chroma, input logic [CAT_W-1:0] cat);
		huff_t h;
		h = '{code: '0, len: 4'd0};
		if (!chroma) begin
			case (cat)
				4'd0:    h = '{code: 11'b00,        len: 4'd2};
				4'd1:    h = '{code: 11'b010,       len: 4'd3};
				4'd2:    h = '{code: 11'b011,       len: 4'd3};
				4'd3:    h = '{code: 11'b100,       len: 4'd3};
				4'd4:    h = '{code: 11'b101,       len: 4'd3};
				4'd5:    h = '{code: 11'b110,       len: 4'd3};
				4'd6:    h = '{code: 11'b1110,      len: 4'd4};
				4'd7:    h = '{code: 11'b11110,     len: 4'd5};
				4'd8:    h = '{code: 11'b111110,    len: 4'd6};
				4'd9:    h = '{code: 11'b1111110,   len: 4'd7};
				4'd10:   h = '{code: 11'b11111110,  len: 4'd8};
				4'd11:   h = '{code: 11'b111111110, len: 4'd9};
				default: h = '{code: '0, len: 4'd0};
			endcase
		end else begin
			case (cat)
				4'd0:    h = '{code: 11'b00,          len: 4'd2};
				4'd1:    h = '{code: 11'b01,          len: 4'd2};
				4'd2:    h = '{code: 11'b10,          len: 4'd2};
				4'd3:    h = '{code: 11'b110,         len: 4'd3};
				4'd4:    h = '{code: 11'b1110,        len: 4'd4};
				4'd5:    h = '{code: 11'b11110,       len: 4'd5};
				4'd6:    h = '{code: 11'b111110,      len: 4'd6};
				4'd7:    h = '{code: 11'b1111110,     len: 4'd7};
				4'd8:    h = '{code: 11'b11111110,    len: 4'd8};
				4'd9:    h = '{code: 11'b111111110,   len: 4'd9};
				4'd10:   h = '{code: 11'b1111111110,  len: 4'd10};
				4'd11:   h = '{code: 11'b11111111110, len: 4'd11};
				default: h = '{code: '0, len: 4'd0};
			endcase
		end
		return h;
	endfunction

endpackage

// ===== design/jdc_in_if.sv =====
// valid/ready channel carrying one block item into the coder
interface jdc_in_if #(parameter int COEFF_BITS = jdc_pkg::COEFF_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic [1:0]                   component;
	logic signed [COEFF_BITS-1:0] dc_coeff;

	modport source(output valid, action, component, dc_coeff, input ready);
	modport sink(input valid, action, component, dc_coeff, output ready);
endinterface

// ===== design/jdc_out_if.sv =====
// valid/ready channel carrying coded stream bytes out of the coder
interface jdc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, out_byte, last, input ready);
	modport sink(input valid, out_byte, last, output ready);
endinterface

// ===== design/jdc_front.sv =====
// front end: rounding, prediction, category and huffman bit packet assembly
module jdc_front #(
	parameter int COEFF_BITS = jdc_pkg::COEFF_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	jdc_in_if.sink        blocks,
	output logic          cmd_valid,
	output jdc_pkg::cmd_t cmd,
	input  logic          cmd_full
);
	import jdc_pkg::*;

	localparam int PW = COEFF_BITS - 2;
	localparam int DW = COEFF_BITS - 1;
	localparam int SW = (DW > SAT_W) ? DW : SAT_W;

	logic                         accept;
	logic                         keep;
	logic signed [COEFF_BITS-1:0] x;
	logic        [COEFF_BITS:0]   sum;
	logic        [PW-1:0]         dc;
	logic        [PW-1:0]         pred_sel;
	logic        [PW-1:0]         pred_q [3];

	logic          valid_s1;
	logic [1:0]    kind_s1;
	logic          chroma_s1;
	logic [DW-1:0] diff_s1;

	logic signed [SW-1:0]    diff_x;
	logic        [SAT_W-1:0] sat;
	logic                    neg;
	logic        [MAG_W-1:0] mag;
	logic        [MAG_W-1:0] vbits;
	logic        [CAT_W-1:0] cat;
	huff_t                   huff;
	logic        [PKT_W-1:0] code_sh;

	// input handshake; items with unused codes are taken and dropped
	assign blocks.ready = !valid_s1 || !cmd_full;
	assign accept = blocks.valid && blocks.ready;
	assign keep = (blocks.action == ACT_CODE && blocks.component != 2'd3) ||
		blocks.action == ACT_FLUSH || blocks.action == ACT_RESTART;

	// rounding dc = (x + 4) >> 3, floor
	assign x   = blocks.dc_coeff;
	assign sum = {x[COEFF_BITS-1], x} + (COEFF_BITS+1)'(4);
	assign dc  = sum[COEFF_BITS:3];

	// predictor of the addressed component
	always_comb begin
		case (blocks.component)
			COMP_CB: pred_sel = pred_q[1];
			COMP_CR: pred_sel = pred_q[2];
			default: pred_sel = pred_q[0];
		endcase
	end

	// predictors and stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < 3; i++) pred_q[i] <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= keep;
				if (blocks.action == ACT_RESTART) begin
					for (int i = 0; i < 3; i++) pred_q[i] <= '0;
				end else if (blocks.action == ACT_CODE && blocks.component != 2'd3) begin
					pred_q[blocks.component] <= dc;
				end
			end else if (valid_s1 && !cmd_full) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= blocks.action;
			chroma_s1 <= blocks.component != COMP_LUMA;
			diff_s1   <= {dc[PW-1], dc} - {pred_sel[PW-1], pred_sel};
		end
	end

	// saturation, magnitude and size category
	always_comb begin
		diff_x = SW'($signed(diff_s1));
		if (diff_x > SW'(DIFF_LIMIT)) sat = SAT_W'(DIFF_LIMIT);
		else if (diff_x < -SW'(DIFF_LIMIT)) sat = SAT_W'(-DIFF_LIMIT);
		else sat = diff_x[SAT_W-1:0];
		neg = sat[SAT_W-1];
		mag = neg ? MAG_W'(-sat) : sat[MAG_W-1:0];
		cat = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (mag[i]) cat = CAT_W'(i + 1);
		end
		vbits = (neg ? ~mag : mag) & ((MAG_W'(1) << cat) - MAG_W'(1));
	end

	// bit packet: huffman code, magnitude bits, end of block; empty for flush and restart
	always_comb begin
		huff    = dc_huff(chroma_s1, cat);
		code_sh = (PKT_W'(huff.code) << cat) | PKT_W'(vbits);
		cmd.kind = kind_s1;
		if (kind_s1 != ACT_CODE) begin
			cmd.bits = '0;
			cmd.len  = '0;
		end else if (chroma_s1) begin
			cmd.bits = code_sh << EOB_CHROMA_LEN;
			cmd.len  = LEN_W'(huff.len) + LEN_W'(cat) + EOB_CHROMA_LEN;
		end else begin
			cmd.bits = (code_sh << EOB_LUMA_LEN) | PKT_W'(EOB_LUMA);
			cmd.len  = LEN_W'(huff.len) + LEN_W'(cat) + EOB_LUMA_LEN;
		end
	end

	assign cmd_valid = valid_s1;

	// a restart leaves every predictor at zero
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && blocks.action == ACT_RESTART) |=>
		(pred_q[0] == '0 && pred_q[1] == '0 && pred_q[2] == '0))
		else $error("predictor not cleared by restart");

endmodule

// ===== design/jdc_queue.sv =====
// two-entry command queue between front and back end
module jdc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jdc_pkg::cmd_t cmd_in,
	output logic          full,
	input  logic          pop,
	output jdc_pkg::cmd_t cmd_out,
	output logic          not_empty
);
	import jdc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign cmd_out   = slot_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= cmd_in;
	end

	// fill count stays within depth and the pointers agree with it
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != 2'd3) && ((cnt_q == 2'd1) == (wr_q != rd_q)))
		else $error("queue count out of step with pointers");

endmodule

// ===== design/jdc_back.sv =====
// back end: bit accumulator, byte packing, 0xff stuffing and output register
module jdc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  jdc_pkg::cmd_t cmd,
	output logic          pop,
	jdc_out_if.source     stream
);
	import jdc_pkg::*;

	localparam int ACC_W = 31;

	logic [6:0]       pend_q;
	logic [2:0]       pcnt_q;
	logic [ACC_W-1:0] work_q;
	logic [1:0]       left_q;
	logic             stuff_q;
	logic             ov_q;
	logic [7:0]       byte_q;
	logic             last_q;

	logic             busy;
	logic [7:0]       cur_byte;
	logic             emit_en;
	logic             final_now;

	logic [LEN_W-1:0] cnt;
	logic [ACC_W-1:0] acc;
	logic [7:0]       fbyte;
	logic [ACC_W-1:0] work_ld;
	logic [1:0]       left_ld;
	logic [6:0]       pend_ld;
	logic [2:0]       pcnt_ld;

	// byte emission control
	assign busy      = stuff_q || left_q != 2'd0;
	assign cur_byte  = work_q[ACC_W-1 -: 8];
	assign emit_en   = busy && (!ov_q || stream.ready);
	assign final_now = emit_en && (stuff_q ? left_q == 2'd0 :
		(left_q == 2'd1 && cur_byte != BYTE_FF));
	assign pop       = cmd_valid && (!busy || final_now);

	// merge a command with the pending bits
	always_comb begin
		cnt     = LEN_W'(pcnt_q) + cmd.len;
		acc     = (ACC_W'(pend_q) << cmd.len) | ACC_W'(cmd.bits);
		fbyte   = (8'(pend_q) << (4'd8 - 4'(pcnt_q))) | (BYTE_FF >> pcnt_q);
		work_ld = '0;
		left_ld = 2'd0;
		pend_ld = pend_q;
		pcnt_ld = pcnt_q;
		case (cmd.kind)
			ACT_CODE: begin
				work_ld = acc << (LEN_W'(ACC_W) - cnt);
				left_ld = cnt[4:3];
				pend_ld = acc[6:0] & ((7'd1 << cnt[2:0]) - 7'd1);
				pcnt_ld = cnt[2:0];
			end
			ACT_FLUSH: begin
				work_ld = {fbyte, (ACC_W-8)'(0)};
				left_ld = (pcnt_q != 3'd0) ? 2'd1 : 2'd0;
				pend_ld = '0;
				pcnt_ld = '0;
			end
			ACT_RESTART: begin
				pend_ld = '0;
				pcnt_ld = '0;
			end
			default: begin
				pend_ld = pend_q;
				pcnt_ld = pcnt_q;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			left_q  <= 2'd0;
			stuff_q <= 1'b0;
			pend_q  <= '0;
			pcnt_q  <= '0;
		end else begin
			if (emit_en) begin
				ov_q <= 1'b1;
			end else if (stream.ready) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				left_q  <= left_ld;
				stuff_q <= 1'b0;
				pend_q  <= pend_ld;
				pcnt_q  <= pcnt_ld;
			end else if (emit_en) begin
				if (stuff_q) begin
					stuff_q <= 1'b0;
				end else begin
					left_q  <= left_q - 2'd1;
					stuff_q <= cur_byte == BYTE_FF;
				end
			end
		end
	end

	// byte shifter and output payload
	always_ff @(posedge clk) begin
		if (emit_en) begin
			byte_q <= stuff_q ? BYTE_STUFF : cur_byte;
			last_q <= final_now;
		end
		if (pop) begin
			work_q <= work_ld;
		end else if (emit_en && !stuff_q) begin
			work_q <= work_q << 8;
		end
	end

	assign stream.valid    = ov_q;
	assign stream.out_byte = byte_q;
	assign stream.last     = last_q;

	// an item never ends on an unstuffed 0xff
	a_no_last_ff: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(last_q && byte_q == BYTE_FF))
		else $error("item ends on 0xff without stuffed zero");

	// every emitted 0xff is followed by a stuffed zero
	a_stuff_after_ff: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_en && !stuff_q && cur_byte == BYTE_FF) |=> stuff_q)
		else $error("stuffing missed after 0xff");

endmodule

// ===== design/jpeg_dc_entropy_coder_unit.sv =====
// Baseline DC entropy coder: one item is one block (code), a flush or a restart.
// The front end takes one item per cycle unless a full queue stalls it, rounds
// the coefficient, forms the difference to the component predictor and builds
// the Huffman bit packet (category code, magnitude bits, end-of-block code); a
// two-entry queue then feeds the back end, which packs bits MSB first and sends
// one byte per cycle while the receiver is ready, a stuffed 0x00 after each 0xFF
// going out as a byte of its own. A code item thus yields 0 to 3 bytes plus
// stuffing; the back-end byte shifter sets the sustained rate. An item passes
// the stage-one register, the queue, the back-end work register and the output
// byte register. last marks the final byte of each item; items that yield no
// byte (restart, empty flush, short code) produce nothing on the output.
module jpeg_dc_entropy_coder_unit #(
	parameter int COEFF_BITS = jdc_pkg::COEFF_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	jdc_in_if.sink    blocks,
	jdc_out_if.source stream
);
	import jdc_pkg::*;

	logic push;
	cmd_t front_cmd;
	logic q_full;
	logic pop;
	cmd_t back_cmd;
	logic q_valid;

	// classification and bit packet assembly
	jdc_front #(.COEFF_BITS(COEFF_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.blocks    (blocks),
		.cmd_valid (push),
		.cmd       (front_cmd),
		.cmd_full  (q_full)
	);

	// decoupling queue
	jdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd_in    (front_cmd),
		.full      (q_full),
		.pop       (pop),
		.cmd_out   (back_cmd),
		.not_empty (q_valid)
	);

	// byte packing and stuffing
	jdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.pop       (pop),
		.stream    (stream)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the dc entropy coder: random and directed blocks against a bit-level predictor
`timescale 1ns / 1ps

module testbench;
	import jdc_pkg::*;

	localparam int CB          = COEFF_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN       = 40;
	localparam int HOLD_LEN    = 300;
	localparam int N_RANDOM    = 160;

	// codes the block has no use for
	localparam logic [1:0] ACT_NONE  = 2'd3;
	localparam logic [1:0] COMP_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]           action;
		logic [1:0]           component;
		logic signed [CB-1:0] coeff;
	} blk_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} coded_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jdc_in_if #(.COEFF_BITS(CB)) blk_if ();
	jdc_out_if byte_if ();

	jpeg_dc_entropy_coder_unit #(.COEFF_BITS(CB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.blocks(blk_if),
		.stream(byte_if)
	);

	// driven copies of the block inputs, known from time zero
	blk_item_t cur_item = '0;
	logic drv_valid = 1'b0;
	logic sink_ready = 1'b0;

	assign blk_if.valid     = drv_valid;
	assign blk_if.action    = cur_item.action;
	assign blk_if.component = cur_item.component;
	assign blk_if.dc_coeff  = cur_item.coeff;
	assign byte_if.ready    = sink_ready;

	blk_item_t   pend_items[$];
	coded_byte_t due_bytes[$];
	logic [7:0]  item_bytes[$];

	// predictor state: last rounded dc per component and the partial byte
	int          dc_last[3] = '{0, 0, 0};
	logic [31:0] bit_acc = '0;
	int          bit_cnt = 0;

	int err_count = 0;
	int items_taken = 0;
	int gap_left = 0;
	int stall_left = 0;
	int stall_draw;
	int hold_left = 0;
	logic hold_used = 1'b0;
	int cycles = 0;
	blk_item_t nxt_item;

	wire burst   = items_taken >= 40 && items_taken < 70;
	wire hold_on = hold_left != 0;

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	// number of huffman codes of a given length in the baseline dc tables
	function automatic int codes_at_len(input bit chroma, input int l);
		if (!chroma)
			return (l == 2) ? 1 : (l == 3) ? 5 : (l >= 4 && l <= 9) ? 1 : 0;
		return (l == 2) ? 3 : (l >= 3 && l <= 11) ? 1 : 0;
	endfunction

	// canonical code for a size category, built from the code-length counts
	task automatic dc_size_code(input bit chroma, input int cat, output int code,
			output int len);
		int c;
		int idx;
		int l;
		int i;
		c = 0;
		idx = 0;
		code = 0;
		len = 0;
		for (l = 1; l <= 16; l++) begin
			for (i = 0; i < codes_at_len(chroma, l); i++) begin
				if (idx == cat && len == 0) begin
					code = c;
					len = l;
				end
				idx++;
				c++;
			end
			c = c << 1;
		end
	endtask

	// msb-first packing, zero byte stuffed after each 0xff
	task automatic append_bits(input int unsigned bits, input int len);
		logic [31:0] acc;
		int cnt;
		logic [7:0] b;
		if (len == 0)
			return;
		acc = (bit_acc << len) | (bits & ((32'd1 << len) - 32'd1));
		cnt = bit_cnt + len;
		while (cnt >= 8) begin
			b = 8'(acc >> (cnt - 8));
			item_bytes.push_back(b);
			if (b == BYTE_FF)
				item_bytes.push_back(BYTE_STUFF);
			cnt -= 8;
		end
		bit_acc = acc & ((32'd1 << cnt) - 32'd1);
		bit_cnt = cnt;
	endtask

	// expected bytes of one accepted item
	task automatic code_item(input blk_item_t it);
		int x;
		int dc;
		int diff;
		int mag;
		int cat;
		int code;
		int len;
		int k;
		bit chroma;
		item_bytes.delete();
		case (it.action)
			ACT_CODE: begin
				if (it.component <= COMP_CR) begin
					x = int'($signed(it.coeff));
					dc = (x + 4) >>> 3;
					diff = dc - dc_last[it.component];
					dc_last[it.component] = dc;
					if (diff > DIFF_LIMIT)
						diff = DIFF_LIMIT;
					if (diff < -DIFF_LIMIT)
						diff = -DIFF_LIMIT;
					mag = diff < 0 ? -diff : diff;
					cat = 0;
					while (mag != 0) begin
						cat++;
						mag = mag >> 1;
					end
					chroma = it.component != COMP_LUMA;
					dc_size_code(chroma, cat, code, len);
					append_bits(code, len);
					if (cat != 0)
						append_bits(diff < 0 ? diff + (1 << cat) - 1 : diff, cat);
					if (chroma)
						append_bits(0, EOB_CHROMA_LEN);
					else
						append_bits(EOB_LUMA, EOB_LUMA_LEN);
				end
			end
			ACT_FLUSH: begin
				if (bit_cnt != 0)
					append_bits(8'h7F, 8 - bit_cnt);
				bit_acc = '0;
				bit_cnt = 0;
			end
			ACT_RESTART: begin
				dc_last = '{0, 0, 0};
				bit_acc = '0;
				bit_cnt = 0;
			end
			default: ;
		endcase
		for (k = 0; k < item_bytes.size(); k++)
			due_bytes.push_back('{data: item_bytes[k], last: k == item_bytes.size() - 1});
	endtask

	task automatic add_item(input logic [1:0] act, input logic [1:0] comp, input int coeff);
		blk_item_t it;
		it.action = act;
		it.component = comp;
		it.coeff = CB'(coeff);
		pend_items.push_back(it);
	endtask

	task automatic build_stimulus();
		int counted;
		int r;
		int sel;
		int x;
		logic [1:0] comp;
		int last_x[3];
		last_x = '{0, 0, 0};
		// directed: extremes, every action, unused codes, stuffing
		add_item(ACT_CODE, COMP_LUMA, 0);
		add_item(ACT_CODE, COMP_LUMA, 2047);
		add_item(ACT_CODE, COMP_LUMA, -2048);
		add_item(ACT_CODE, COMP_CB, 2047);
		add_item(ACT_CODE, COMP_CR, -2048);
		add_item(ACT_CODE, COMP_CR, 0);
		add_item(ACT_CODE, COMP_NONE, 100);
		add_item(ACT_NONE, COMP_LUMA, -77);
		add_item(ACT_FLUSH, COMP_LUMA, 0);
		add_item(ACT_FLUSH, COMP_CB, 0);
		add_item(ACT_CODE, COMP_CB, 5);
		add_item(ACT_CODE, COMP_CB, -5);
		add_item(ACT_CODE, COMP_CR, 3);
		add_item(ACT_RESTART, COMP_CR, 1234);
		add_item(ACT_CODE, COMP_LUMA, -2040);
		add_item(ACT_FLUSH, COMP_LUMA, 0);
		add_item(ACT_CODE, COMP_LUMA, 2047);
		add_item(ACT_FLUSH, COMP_LUMA, 0);
		add_item(ACT_CODE, COMP_CB, 1000);
		add_item(ACT_RESTART, COMP_LUMA, 0);
		add_item(ACT_FLUSH, COMP_LUMA, 0);
		add_item(ACT_CODE, COMP_LUMA, -4);
		add_item(ACT_CODE, COMP_CR, -1);
		add_item(ACT_FLUSH, COMP_CR, -1);
		// random: mostly coded blocks, some flushes, restarts and ignored codes
		counted = 0;
		while (counted < N_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				comp = 2'($urandom_range(0, 2));
				sel = $urandom_range(0, 9);
				if (sel < 5)
					x = $signed(CB'($urandom));
				else if (sel < 8)
					x = last_x[comp] + $urandom_range(0, 80) - 40;
				else
					x = $urandom_range(0, 1) ? 2047 : -2048;
				if (x > 2047)
					x = 2047;
				if (x < -2048)
					x = -2048;
				last_x[comp] = x;
				add_item(ACT_CODE, comp, x);
				counted++;
			end else if (r < 83) begin
				add_item(ACT_CODE, COMP_NONE, $urandom);
			end else if (r < 91) begin
				add_item(ACT_FLUSH, 2'($urandom_range(0, 3)), $urandom);
				counted++;
			end else if (r < 95) begin
				add_item(ACT_RESTART, 2'($urandom_range(0, 3)), $urandom);
				counted++;
			end else begin
				add_item(ACT_NONE, 2'($urandom_range(0, 3)), $urandom);
			end
		end
	endtask

	// driver: offers queued items with a random gap between them, none during the burst
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (drv_valid && blk_if.ready) begin
				code_item(cur_item);
				items_taken <= items_taken + 1;
			end
			if (!drv_valid || blk_if.ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					drv_valid <= 1'b0;
				end else if (pend_items.size() != 0) begin
					nxt_item = pend_items.pop_front();
					cur_item <= nxt_item;
					drv_valid <= 1'b1;
					gap_left <= burst ? 0 : $urandom_range(0, 4);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each byte and stalls at random before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (byte_if.valid && sink_ready) begin
				if (due_bytes.size() == 0) begin
					note_mismatch($sformatf("unexpected byte %02h last %0b",
						byte_if.out_byte, byte_if.last));
				end else begin
					if (byte_if.out_byte !== due_bytes[0].data)
						note_mismatch($sformatf("out_byte %02h, wanted %02h",
							byte_if.out_byte, due_bytes[0].data));
					if (byte_if.last !== due_bytes[0].last)
						note_mismatch($sformatf("last %0b on byte %02h, wanted %0b",
							byte_if.last, byte_if.out_byte, due_bytes[0].last));
					void'(due_bytes.pop_front());
				end
				stall_draw = burst ? 0 : $urandom_range(0, 4);
				stall_left <= stall_draw;
				sink_ready <= stall_draw == 0 && !hold_on;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				sink_ready <= stall_left == 1 && !hold_on;
			end else begin
				sink_ready <= !hold_on;
			end
		end
	end

	// one long receiver hold-off while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && items_taken >= 120) begin
			hold_left <= HOLD_LEN;
			hold_used <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pend_items.size() != 0 || drv_valid || due_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (err_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
